@@ rtl/core/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the adaptive sample rate tuner
// Field widths, reset values, register indexes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package ast_pkg;

  localparam int unsigned TsW      = 64;
  localparam int unsigned GoalW    = 16;
  localparam int unsigned PeriodW  = 30;
  localparam int unsigned RateW    = 24;
  localparam int unsigned CountW   = 32;
  localparam int unsigned ProdW    = RateW + CountW;
  // A rate step is kept to this many bits; anything larger always hits rate_max.
  localparam int unsigned StepW    = 28;
  localparam int unsigned NextW    = StepW + 1;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // One tenth scaled by 2^32 and rounded up; exact for dividends below 2^30.
  localparam int unsigned RecipW     = 29;
  localparam int unsigned RecipShift = 32;

  localparam logic [RateW-1:0]   RateFloor    = 24'h010000;
  localparam logic [RateW-1:0]   RateMaxReset = 24'hFFFFFF;
  localparam logic [PeriodW-1:0] PeriodReset  = 30'd1000000000;
  localparam logic [GoalW-1:0]   GoalReset    = 16'd0;
  localparam logic [GoalW-1:0]   RateInertia  = 16'd10;
  localparam logic [RecipW-1:0]  Recip10      = 29'h1999999A;

  localparam logic [DivCntW-1:0] EstSteps = DivCntW'(ProdW - 1);

  typedef enum logic [1:0] {
    RegGoal      = 2'd0,
    RegPeriod    = 2'd1,
    RegRateMax   = 2'd2,
    RegStartRate = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GoalW-1:0]   goal;
    logic [PeriodW-1:0] period;
    logic [RateW-1:0]   rate_max;
    logic [RateW-1:0]   start_rate;
  } cfg_t;

  typedef struct packed {
    logic ts_load;
    logic diff_load;
    logic count_inc;
    logic mul_load;
    logic div_step;
    logic delta_load;
    logic step_load;
    logic apply;
    logic result_load;
    logic adjusted;
  } dp_cmd_t;

  typedef struct packed {
    logic raw;
    logic due;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/ast_if.sv @@
// ----------------------------------------------------------------------------
// ast_if: valid/ready channels of the adaptive sample rate tuner
// One interface for the interrupt timestamps, one for the rate results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ast_in_if
  import ast_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [TsW-1:0] timestamp_ns;

  modport source (output valid, output timestamp_ns, input ready);
  modport sink   (input valid, input timestamp_ns, output ready);
endinterface

interface ast_out_if
  import ast_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [RateW-1:0] rate;
  logic             adjusted;

  modport source (output valid, output rate, output adjusted, input ready);
  modport sink   (input valid, input rate, input adjusted, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ast_apb_regs.sv @@
// ----------------------------------------------------------------------------
// ast_apb_regs: configuration registers behind an APB-style port
// Holds goal, tick period, rate ceiling and start rate; a write to the start
// rate also pulses a load of the running rate.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_apb_regs
  import ast_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o,
  output logic                     rate_load_o
);

  cfg_t     cfg_q, cfg_d;
  logic     rate_load_q, rate_load_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d       = cfg_q;
    rate_load_d = 1'b0;
    if (wr_en) begin
      unique case (idx)
        RegGoal:      cfg_d.goal     = pwdata[GoalW-1:0];
        RegPeriod:    cfg_d.period   = pwdata[PeriodW-1:0];
        RegRateMax:   cfg_d.rate_max = pwdata[RateW-1:0];
        RegStartRate: begin
          cfg_d.start_rate = pwdata[RateW-1:0];
          rate_load_d      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegGoal:      prdata = ApbDataW'(cfg_q.goal);
      RegPeriod:    prdata = ApbDataW'(cfg_q.period);
      RegRateMax:   prdata = ApbDataW'(cfg_q.rate_max);
      RegStartRate: prdata = ApbDataW'(cfg_q.start_rate);
      default:      prdata = '0;
    endcase
  end

  // The load pulse is registered, so the running rate loads once the new start
  // rate sits in its register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal       <= GoalReset;
      cfg_q.period     <= PeriodReset;
      cfg_q.rate_max   <= RateMaxReset;
      cfg_q.start_rate <= RateFloor;
      rate_load_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      rate_load_q <= rate_load_d;
    end
  end

  assign cfg_o       = cfg_q;
  assign rate_load_o = rate_load_q;

endmodule

`default_nettype wire

@@ rtl/core/ast_dp.sv @@
// ----------------------------------------------------------------------------
// ast_dp: datapath of the adaptive sample rate tuner
// Tuner state, elapsed-time check, rate-by-count multiplier, a bit-serial
// divider for the estimate, a reciprocal multiply for the step by ten and the
// clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_dp
  import ast_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             rate_load_i,
  input  wire logic [TsW-1:0]   timestamp_ns_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_status_t            status_o,
  output logic      [RateW-1:0] rate_o,
  output logic                  adjusted_o
);

  logic [TsW-1:0]    ts_q;
  logic [TsW-1:0]    last_q, last_d;
  logic [CountW-1:0] count_q, count_d;
  logic [RateW-1:0]  rate_q, rate_d;
  logic [TsW-1:0]    diff_q;
  logic              borrow_q;
  logic [ProdW-1:0]  quo_q, quo_d;
  logic [GoalW-1:0]  rem_q, rem_d;
  logic [GoalW-1:0]  dvsr_q, dvsr_d;
  logic              lt_q, sat_q;
  logic [StepW-1:0]  mag_q;
  logic [StepW-1:0]  step_q;
  logic [RateW-1:0]  res_rate_q;
  logic              res_adj_q;

  logic [TsW:0]            diff_full;
  logic [GoalW+1:0]        trial;
  logic [ProdW:0]          est_sub;
  logic [RateW-1:0]        down_mag;
  logic [StepW-1:0]        mag;
  logic [StepW+RecipW-1:0] step_prod;
  logic [NextW-1:0]        next_raw, next_floor, next_rate;

  assign diff_full = {1'b0, ts_q} - {1'b0, last_q};

  assign status_o.raw = (cfg_i.goal == '0);
  // Strictly later and strictly more than one period; a borrow means time went back.
  assign status_o.due = !borrow_q && (diff_q > TsW'(cfg_i.period));

  // Restoring division step: shift one dividend bit into the remainder.
  assign trial = {1'b0, rem_q, quo_q[ProdW-1]} - {2'b00, dvsr_q};

  // Distance of the estimate from the current rate.
  assign est_sub  = {1'b0, quo_q} - {(ProdW-RateW+1)'(0), rate_q};
  assign down_mag = rate_q - quo_q[RateW-1:0];
  assign mag      = est_sub[ProdW] ? StepW'(down_mag) : est_sub[StepW-1:0];

  // Multiplying by the scaled reciprocal and dropping the scale divides by ten.
  assign step_prod = (StepW+RecipW)'(mag_q) * (StepW+RecipW)'(Recip10);

  always_comb begin
    if (lt_q) begin
      next_raw = NextW'(rate_q) - NextW'(step_q);
    end else if (sat_q) begin
      next_raw = '1;
    end else begin
      next_raw = NextW'(rate_q) + NextW'(step_q);
    end
    next_floor = (next_raw < NextW'(RateFloor)) ? NextW'(RateFloor) : next_raw;
    next_rate  = (next_floor > NextW'(cfg_i.rate_max)) ? NextW'(cfg_i.rate_max)
                                                       : next_floor;
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (cmd_i.mul_load) begin
      quo_d  = ProdW'(rate_q) * ProdW'(count_q);
      rem_d  = '0;
      dvsr_d = cfg_i.goal;
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[ProdW-2:0], !trial[GoalW+1]};
      rem_d = trial[GoalW+1] ? {rem_q[GoalW-2:0], quo_q[ProdW-1]} : trial[GoalW-1:0];
    end
  end

  always_comb begin
    last_d  = last_q;
    count_d = count_q;
    rate_d  = rate_q;
    if (rate_load_i) begin
      rate_d = cfg_i.start_rate;
    end else if (cmd_i.apply) begin
      rate_d  = next_rate[RateW-1:0];
      last_d  = ts_q;
      count_d = CountW'(1);
    end else if (cmd_i.count_inc && (count_q != '1)) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      count_q <= '0;
      rate_q  <= RateFloor;
    end else begin
      last_q  <= last_d;
      count_q <= count_d;
      rate_q  <= rate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    if (cmd_i.ts_load) begin
      ts_q <= timestamp_ns_i;
    end
    if (cmd_i.diff_load) begin
      diff_q   <= diff_full[TsW-1:0];
      borrow_q <= diff_full[TsW];
    end
    if (cmd_i.delta_load) begin
      lt_q  <= est_sub[ProdW];
      sat_q <= (est_sub[ProdW-1:StepW] != '0);
      mag_q <= mag;
    end
    if (cmd_i.step_load) begin
      step_q <= StepW'(step_prod[StepW+RecipW-1:RecipShift]);
    end
    if (cmd_i.result_load) begin
      res_rate_q <= rate_q;
      res_adj_q  <= cmd_i.adjusted;
    end
  end

  assign rate_o     = res_rate_q;
  assign adjusted_o = res_adj_q;

endmodule

`default_nettype wire

@@ rtl/core/ast_ctrl.sv @@
// ----------------------------------------------------------------------------
// ast_ctrl: sequencing controller of the adaptive sample rate tuner
// Walks one interrupt through check, multiply, the estimate division, the
// step by ten and the rate update, and owns the handshakes and the output
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_ctrl
  import ast_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDiff  = 9'b000000010,
    StCmp   = 9'b000000100,
    StMul   = 9'b000001000,
    StDiv   = 9'b000010000,
    StDelta = 9'b000100000,
    StDiv10 = 9'b001000000,
    StApply = 9'b010000000,
    StEmit  = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               adj_q, adj_d;
  logic               out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    adj_d       = adj_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.ts_load = 1'b1;
          adj_d         = 1'b0;
          state_d       = StDiff;
        end
      end
      StDiff: begin
        if (status_i.raw) begin
          state_d = StEmit;
        end else begin
          cmd_o.diff_load = 1'b1;
          state_d         = StCmp;
        end
      end
      StCmp: begin
        if (status_i.due) begin
          state_d = StMul;
        end else begin
          cmd_o.count_inc = 1'b1;
          state_d         = StEmit;
        end
      end
      StMul: begin
        cmd_o.mul_load = 1'b1;
        cnt_d          = EstSteps;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StDelta;
        end else begin
          cnt_d = cnt_q - DivCntW'(1);
        end
      end
      StDelta: begin
        cmd_o.delta_load = 1'b1;
        state_d          = StDiv10;
      end
      StDiv10: begin
        cmd_o.step_load = 1'b1;
        state_d         = StApply;
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        adj_d       = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        // The output register is free once its previous transaction completes.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          cmd_o.adjusted    = adj_q;
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      adj_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      adj_q       <= adj_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/adaptive_sample_rate_tuner.sv @@
// ----------------------------------------------------------------------------
// adaptive_sample_rate_tuner: top level of the sampling rate tuner
// Takes one timestamped interrupt per input transaction and returns the rate.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries the nanosecond timestamp of each sampling interrupt; out_o
//   returns one result per interrupt: the rate after it and whether this
//   interrupt adjusted it. Registers sit behind the APB-style port at byte
//   addresses 0 (goal), 4 (tick period), 8 (rate ceiling), 12 (start rate);
//   writing the start rate also loads the running rate.
//   An adjustment runs the bit-serial divider for the estimate, 56 steps,
//   while the tenth-of-the-way step comes from a reciprocal multiplication.
//   One interrupt is in work at a time; a new one is taken as soon as the
//   previous result sits in the output register, even if not yet taken.
//   If the receiver stalls, the finished next result waits until the output
//   register frees up. Reset loads the default registers, a rate of 65536,
//   a last tick time of zero and a cleared interrupt count.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_sample_rate_tuner
  import ast_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ast_in_if.sink                   in_i,
  ast_out_if.source                out_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  cfg_t       cfg;
  logic       rate_load;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  ast_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .rate_load_o (rate_load)
  );

  ast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ast_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .rate_load_i    (rate_load),
    .timestamp_ns_i (in_i.timestamp_ns),
    .cmd_i          (cmd),
    .status_o       (status),
    .rate_o         (out_o.rate),
    .adjusted_o     (out_o.adjusted)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

@@ tb/tb_adaptive_sample_rate_tuner.sv @@
// ----------------------------------------------------------------------------
// tb_adaptive_sample_rate_tuner: self-checking bench for the rate tuner
// Streams timestamped interrupts through the block under random burst and
// stall patterns and predicts every rate result in-bench. Register settings
// change between phases over the APB-style port, with the extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_adaptive_sample_rate_tuner;
  import ast_pkg::*;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic             adjusted;
  } rate_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ast_in_if  in_if ();
  ast_out_if out_if ();

  adaptive_sample_rate_tuner dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies and running state of the predictor.
  logic [GoalW-1:0]   cfg_goal       = GoalReset;
  logic [PeriodW-1:0] cfg_period     = PeriodReset;
  logic [RateW-1:0]   cfg_rate_max   = RateMaxReset;
  logic [RateW-1:0]   cfg_start_rate = RateFloor;
  logic [RateW-1:0]   run_rate       = RateFloor;
  logic [TsW-1:0]     last_tick_ns   = '0;
  logic [CountW-1:0]  irq_count      = '0;

  logic [TsW-1:0] pending_ts[$];
  rate_result_t   rate_expect[$];

  int n_taken    = 0;
  int err_count  = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  int holds_done = 0;
  int seg_left   = 0;
  int seg_mode   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic rate_result_t tune_rate(input logic [TsW-1:0] now_ns);
    rate_result_t res;
    logic [63:0]  cur;
    logic [63:0]  est;
    logic [63:0]  nxt;
    res.adjusted = 1'b0;
    if (cfg_goal != '0) begin
      // A timestamp at or before the last tick never counts as elapsed time.
      if (now_ns > last_tick_ns && (now_ns - last_tick_ns) > 64'(cfg_period)) begin
        cur = 64'(run_rate);
        est = (cur * 64'(irq_count)) / 64'(cfg_goal);
        if (est < cur) begin
          nxt = cur - (cur - est) / 64'(RateInertia);
        end else begin
          nxt = cur + (est - cur) / 64'(RateInertia);
        end
        if (nxt < 64'(RateFloor)) nxt = 64'(RateFloor);
        if (nxt > 64'(cfg_rate_max)) nxt = 64'(cfg_rate_max);
        run_rate     = nxt[RateW-1:0];
        last_tick_ns = now_ns;
        irq_count    = '0;
        res.adjusted = 1'b1;
      end
      if (irq_count != '1) irq_count = irq_count + 1'b1;
    end
    res.rate = run_rate;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegGoal:      cfg_goal = val[GoalW-1:0];
      RegPeriod:    cfg_period = val[PeriodW-1:0];
      RegRateMax:   cfg_rate_max = val[RateW-1:0];
      RegStartRate: begin
        cfg_start_rate = val[RateW-1:0];
        run_rate       = val[RateW-1:0];
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_ts.size() != 0 || rate_expect.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Interrupt driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    logic fire;
    logic offer;
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.timestamp_ns <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      fire = in_if.valid && in_if.ready;
      if (fire) begin
        rate_expect.push_back(tune_rate(in_if.timestamp_ns));
        void'(pending_ts.pop_front());
        n_taken++;
      end
      if (in_if.valid && !fire) begin
        offer = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        offer = 1'b0;
      end else if (pending_ts.size() != 0) begin
        offer = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        offer = 1'b0;
      end
      in_if.valid <= offer;
      if (offer && !(in_if.valid && !fire)) in_if.timestamp_ns <= pending_ts[0];
    end
  end

  // Result receiver: segments of full, half and sparse readiness, plus two
  // long hold-offs that back the block up into its input channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left  = 0;
      seg_left   = 0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && n_taken >= (holds_done == 0 ? 250 : 700)) begin
        hold_left = 400;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 60);
          seg_mode = $urandom_range(0, 2);
        end
        seg_left--;
        case (seg_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    rate_result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rate_expect.size() == 0) begin
        flag_error($sformatf("unexpected result rate=%0d adjusted=%0b",
                             out_if.rate, out_if.adjusted));
      end else begin
        exp_res = rate_expect.pop_front();
        if (out_if.rate !== exp_res.rate || out_if.adjusted !== exp_res.adjusted) begin
          flag_error($sformatf("rate exp=%0d got=%0d, adjusted exp=%0b got=%0b",
                               exp_res.rate, out_if.rate, exp_res.adjusted,
                               out_if.adjusted));
        end
      end
    end
  end

  initial begin
    logic [TsW-1:0] t_ns;
    int unsigned    g;
    int unsigned    per;
    int unsigned    rmax;
    int unsigned    step;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Raw mode straight out of reset: nothing may move.
    pending_ts.push_back('0);
    pending_ts.push_back('1);
    pending_ts.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_ts.push_back(64'h5555_5555_5555_5555);
    drain_results();

    // Zero tick period, equal and earlier timestamps.
    cfg_write(RegGoal, 32'd1);
    cfg_write(RegPeriod, 32'd0);
    cfg_write(RegRateMax, 32'h00FF_FFFF);
    pending_ts.push_back(64'd0);
    pending_ts.push_back(64'd5);
    pending_ts.push_back(64'd5);
    pending_ts.push_back(64'd3);
    pending_ts.push_back(64'd6);
    drain_results();

    // Largest goal, period and start rate; the second item falls one short.
    cfg_write(RegStartRate, 32'h00FF_FFFF);
    cfg_write(RegGoal, 32'd65535);
    cfg_write(RegPeriod, 32'h3FFF_FFFF);
    t_ns = 64'd6 + 64'h4000_0000;
    pending_ts.push_back(t_ns);
    pending_ts.push_back(t_ns + 64'h3FFF_FFFF);
    drain_results();

    // Ceiling below the floor and a zero start rate.
    cfg_write(RegRateMax, 32'd1000);
    cfg_write(RegStartRate, 32'd0);
    cfg_write(RegGoal, 32'd3);
    cfg_write(RegPeriod, 32'd10);
    pending_ts.push_back(t_ns);
    pending_ts.push_back(t_ns + 64'd11);
    pending_ts.push_back(t_ns + 64'd22);
    t_ns = t_ns + 64'd22;
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        // Raw mode with fully random timestamps toggles every input bit.
        cfg_write(RegGoal, {16'($urandom()), 16'd0});
        for (int k = 0; k < 60; k++) pending_ts.push_back({$urandom(), $urandom()});
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: g = $urandom_range(1, 16);
          6, 7, 8:          g = $urandom_range(17, 1000);
          default:          g = $urandom_range(1001, 65535);
        endcase
        case (ph)
          1:       per = 0;
          5:       per = 32'h3FFF_FFFF;
          6:       per = 1000000000;
          default: per = $urandom_range(50, 5000);
        endcase
        case (ph)
          2:       rmax = $urandom_range(0, 65535);
          4:       rmax = 65536;
          6:       rmax = 32'h00FF_FFFF;
          default: rmax = $urandom_range(65536, 32'h00FF_FFFF);
        endcase
        cfg_write(RegGoal, {16'($urandom()), 16'(g)});
        cfg_write(RegPeriod, {2'($urandom()), 30'(per)});
        cfg_write(RegRateMax, {8'($urandom()), 24'(rmax)});
        if (ph == 0 || $urandom_range(0, 1) == 1) begin
          cfg_write(RegStartRate, {8'($urandom()), 24'($urandom())});
        end
        step = per / g;
        if (ph == 6) t_ns = t_ns + 64'h8000_0000_0000_0000;
        else t_ns = t_ns + {24'd0, 8'($urandom()), $urandom()};
        for (int k = 0; k < 180; k++) begin
          case ($urandom_range(0, 19))
            0, 1: pending_ts.push_back(t_ns - (t_ns >> $urandom_range(1, 20)));
            2: begin
              t_ns = t_ns + 64'(per) + 64'($urandom_range(1, 3));
              pending_ts.push_back(t_ns);
            end
            default: begin
              t_ns = t_ns + 64'($urandom_range(0, 2 * step + 1));
              pending_ts.push_back(t_ns);
            end
          endcase
        end
        if (ph == 6) pending_ts.push_back('1);
      end
      drain_results();
    end

    repeat (120) @(posedge clk_i);
    err_count += rate_expect.size();
    if (err_count == 0) begin
      $display("tb_adaptive_sample_rate_tuner: clean");
    end else begin
      $display("tb_adaptive_sample_rate_tuner: errors");
    end
    $finish;
  end

  initial begin
    #(64'd8_000_000);
    $display("tb_adaptive_sample_rate_tuner: errors");
    $finish;
  end

endmodule
